### rtl/core/pls_pkg.sv
// pls_pkg: shared types, codes and helpers for the piecewise linear pixel stretch
// no dependencies; imported by pls_cell, pls_slope, piecewise_linear_pixel_stretch and tb_top
package pls_pkg;

	localparam int MAX_PAIRS_DEF = 64;
	localparam int NUM_REGS      = 7;
	localparam int REG_W         = 35;
	localparam int VAL_W         = 32;
	localparam int DIV_STEPS     = 32;

	// register indexes
	localparam logic [2:0] REG_NULL  = 3'd0;
	localparam logic [2:0] REG_LIS   = 3'd1;
	localparam logic [2:0] REG_LRS   = 3'd2;
	localparam logic [2:0] REG_HIS   = 3'd3;
	localparam logic [2:0] REG_HRS   = 3'd4;
	localparam logic [2:0] REG_BELOW = 3'd5;
	localparam logic [2:0] REG_ABOVE = 3'd6;

	localparam logic [REG_W-1:0] RST_NULL  = 35'd4294967296;
	localparam logic [REG_W-1:0] RST_LIS   = 35'd8589934592;
	localparam logic [REG_W-1:0] RST_LRS   = 35'd12884901888;
	localparam logic [REG_W-1:0] RST_HIS   = 35'd17179869184;
	localparam logic [REG_W-1:0] RST_HRS   = 35'd21474836480;
	localparam logic [REG_W-1:0] RST_BELOW = 35'd12884901888;
	localparam logic [REG_W-1:0] RST_ABOVE = 35'd21474836480;

	localparam logic [2:0] CLS_VALID = 3'd0;
	localparam logic [2:0] CLS_LRS   = 3'd3;
	localparam logic [2:0] CLS_HRS   = 3'd5;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_MAP    = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_ORDER = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_SAT   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SLOPE
	} ctl_state_t;

	typedef enum logic [1:0] {
		SL_IDLE,
		SL_ADD,
		SL_DIV
	} slope_state_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [2:0]              in_class;
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] pair_target;
	} req_t;

	typedef struct packed {
		logic [2:0]              out_class;
		logic signed [VAL_W-1:0] out_value;
		logic [1:0]              status;
	} rsp_t;

	// search token walking down the cell row
	typedef struct packed {
		logic                    valid;
		logic                    found;
		logic signed [VAL_W-1:0] v;
		logic signed [VAL_W-1:0] s_in;
		logic signed [VAL_W-1:0] s_out;
		logic signed [VAL_W-1:0] e_in;
		logic signed [VAL_W-1:0] e_out;
	} tok_t;

	function automatic logic [2:0] norm_class(input logic [2:0] c);
		logic [2:0] r;
		r = (c > CLS_HRS) ? CLS_LRS : c;
		return r;
	endfunction

endpackage

### rtl/core/pls_cell.sv
// pls_cell: one breakpoint pair of the table and one stage of the search row
// depends on pls_pkg
module pls_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic signed [31:0]   wr_in,
	input  logic signed [31:0]   wr_out,
	input  pls_pkg::tok_t        tok_in,
	output pls_pkg::tok_t        tok_out
);
	import pls_pkg::*;

	logic signed [VAL_W-1:0] bin_q;
	logic signed [VAL_W-1:0] bout_q;
	logic                    valid_q;
	tok_t                    tok_d;
	tok_t                    tok_q;

	always_ff @(posedge clk) begin
		if (we) begin
			bin_q  <= wr_in;
			bout_q <= wr_out;
		end
	end

	// first cell whose input lies above the pixel ends the segment
	always_comb begin
		tok_d = tok_in;
		if (!tok_in.found) begin
			if (tok_in.v < bin_q) begin
				tok_d.found = 1'b1;
				tok_d.e_in  = bin_q;
				tok_d.e_out = bout_q;
			end else begin
				tok_d.s_in  = bin_q;
				tok_d.s_out = bout_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end

endmodule

### rtl/core/pls_slope.sv
// pls_slope: 32x32 product plus half divisor, then restoring division one bit a cycle
// depends on pls_pkg
module pls_slope (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] ady,
	input  logic [31:0] at,
	input  logic [31:0] dx,
	output logic        done,
	output logic [31:0] quo
);
	import pls_pkg::*;

	slope_state_t state_q, state_d;
	logic [63:0]  prod_q;
	logic [31:0]  dx_q;
	logic [31:0]  rem_q;
	logic [31:0]  low_q;
	logic [4:0]   cnt_q;
	logic         done_q;
	logic [64:0]  num;
	logic [32:0]  trial;
	logic         qbit;
	logic [32:0]  diff;

	assign num   = {1'b0, prod_q} + {33'd0, 1'b0, dx_q[31:1]};
	assign trial = {rem_q, low_q[31]};
	assign qbit  = (trial >= {1'b0, dx_q});
	assign diff  = trial - {1'b0, dx_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SL_IDLE: if (go) state_d = SL_ADD;
			SL_ADD:  state_d = SL_DIV;
			SL_DIV:  if (cnt_q == 5'(DIV_STEPS - 1)) state_d = SL_IDLE;
			default: state_d = SL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SL_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == SL_DIV) && (cnt_q == 5'(DIV_STEPS - 1));
			if (state_q == SL_DIV) cnt_q <= cnt_q + 5'd1;
			else cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			SL_IDLE: begin
				prod_q <= ady * at;
				dx_q   <= dx;
			end
			// numerator high part is below the divisor, so the quotient fits 32 bits
			SL_ADD: begin
				rem_q <= num[63:32];
				low_q <= num[31:0];
			end
			SL_DIV: begin
				rem_q <= qbit ? diff[31:0] : trial[31:0];
				low_q <= {low_q[30:0], qbit};
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign done = done_q;
	assign quo  = low_q;

endmodule

### rtl/core/piecewise_linear_pixel_stretch.sv
// piecewise_linear_pixel_stretch: top level, control, registers and the cell row
// depends on pls_pkg, pls_cell, pls_slope
//
// Usage: a request is taken at a clock edge with start high and busy low.
// req.kind selects clear, append pair, map pixel or none. One result comes back per
// request on rsp, marked by done for exactly one cycle; the receiver cannot
// hold it off. Configuration registers are written through cfg_we, cfg_index
// and cfg_data while no request is in flight; indexes 7 and up are ignored.
// Clear, append, none, special classes, empty table, out-of-range and
// end-point pixels give done in the cycle after the request, busy stays low.
// An interior pixel walks the token row, one cell per cycle; the product is
// registered as the token leaves the last cell, then the divider adds half the
// divisor, runs the restoring division and the quotient is applied to the
// output of the segment end; busy stays high throughout.
// Reset: table empty, configuration registers at their reset classes, no
// result pending. The table contents are undefined until appended.
module piecewise_linear_pixel_stretch #(
	parameter int MAX_PAIRS = pls_pkg::MAX_PAIRS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pls_pkg::req_t req,
	output logic          done,
	output pls_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [34:0]   cfg_data
);
	import pls_pkg::*;

	localparam int CW = $clog2(MAX_PAIRS + 1);

	ctl_state_t state_q, state_d;
	logic [REG_W-1:0]        map_q [NUM_REGS];
	logic [CW-1:0]           cnt_q;
	logic signed [VAL_W-1:0] first_in_q, first_out_q, last_in_q, last_out_q;
	rsp_t                    out_q;
	logic                    done_q;
	logic signed [VAL_W-1:0] e_out_q;
	logic                    pos_q;

	logic                    accept;
	logic                    launch;
	logic                    append_ok;
	rsp_t                    quick;
	tok_t                    chain [MAX_PAIRS+1];
	tok_t                    seg;
	logic signed [32:0]      dy;
	logic [31:0]             ady, dx, at, quo;
	logic                    slope_done;
	logic                    slope_go;
	logic [2:0]              cin, bcls, rcls, rid;
	logic [REG_W-1:0]        bound, rreg;
	logic                    is_below, is_above;

	assign accept = start && !busy;

	// request decode for everything that does not need the cell row and divider
	always_comb begin
		quick     = '0;
		launch    = 1'b0;
		append_ok = 1'b0;
		cin       = norm_class(req.in_class);
		is_below  = req.value < first_in_q;
		is_above  = req.value > last_in_q;
		bound     = is_below ? map_q[REG_BELOW] : map_q[REG_ABOVE];
		bcls      = norm_class(bound[34:32]);
		rid       = (cin != CLS_VALID) ? cin - 3'd1 : bcls - 3'd1;
		rreg      = map_q[rid];
		rcls      = norm_class(rreg[34:32]);
		unique case (req.kind)
			KIND_CLEAR: quick.status = STAT_OK;
			KIND_APPEND: begin
				if (cnt_q != '0 && req.value <= last_in_q) quick.status = STAT_ORDER;
				else if (cnt_q == CW'(MAX_PAIRS)) quick.status = STAT_FULL;
				else append_ok = 1'b1;
			end
			KIND_MAP: begin
				if (cin != CLS_VALID) begin
					quick.out_class = rcls;
					quick.out_value = (rcls == CLS_VALID) ? rreg[31:0] : '0;
				end else if (cnt_q == '0) begin
					quick.out_value = req.value;
				end else if (is_below || is_above) begin
					if (bcls == CLS_VALID) begin
						quick.out_value = bound[31:0];
					end else begin
						quick.out_class = rcls;
						quick.out_value = (rcls == CLS_VALID) ? rreg[31:0] : '0;
					end
				end else if (req.value == first_in_q) begin
					quick.out_value = first_out_q;
				end else if (req.value == last_in_q) begin
					quick.out_value = last_out_q;
				end else begin
					launch = 1'b1;
				end
			end
			KIND_NONE: quick = '0;
			default:   quick = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept && launch) state_d = ST_SEARCH;
			ST_SEARCH: if (seg.valid) state_d = ST_SLOPE;
			ST_SLOPE:  if (slope_done) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = (state_q != ST_IDLE);
		slope_go = (state_q == ST_SEARCH) && seg.valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			map_q[REG_NULL]  <= RST_NULL;
			map_q[REG_LIS]   <= RST_LIS;
			map_q[REG_LRS]   <= RST_LRS;
			map_q[REG_HIS]   <= RST_HIS;
			map_q[REG_HRS]   <= RST_HRS;
			map_q[REG_BELOW] <= RST_BELOW;
			map_q[REG_ABOVE] <= RST_ABOVE;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && !launch) || (state_q == ST_SLOPE && slope_done);
			if (cfg_we && cfg_index < 3'(NUM_REGS)) map_q[cfg_index] <= cfg_data;
			if (accept && req.kind == KIND_CLEAR) cnt_q <= '0;
			else if (accept && append_ok) cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && append_ok) begin
			last_in_q  <= req.value;
			last_out_q <= req.pair_target;
			if (cnt_q == '0) begin
				first_in_q  <= req.value;
				first_out_q <= req.pair_target;
			end
		end
		if (accept && !launch) out_q <= quick;
		if (slope_go) begin
			e_out_q <= seg.e_out;
			pos_q   <= !dy[32] && (dy != '0);
		end
		if (state_q == ST_SLOPE && slope_done) begin
			out_q.out_class <= CLS_VALID;
			out_q.status    <= STAT_OK;
			out_q.out_value <= pos_q ? e_out_q - $signed(quo) : e_out_q + $signed(quo);
		end
	end

	// cell row: token enters at cell 0 and leaves after the last cell
	always_comb begin
		chain[0]       = '0;
		chain[0].valid = accept && launch;
		chain[0].v     = req.value;
	end

	for (genvar k = 0; k < MAX_PAIRS; k++) begin : g_cell
		pls_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.we      (accept && append_ok && cnt_q == CW'(k)),
			.wr_in   (req.value),
			.wr_out  (req.pair_target),
			.tok_in  (chain[k]),
			.tok_out (chain[k+1])
		);
	end

	assign seg = chain[MAX_PAIRS];
	assign dy  = {seg.e_out[31], seg.e_out} - {seg.s_out[31], seg.s_out};
	assign ady = dy[32] ? 32'(-dy) : dy[31:0];
	assign dx  = 32'(seg.e_in - seg.s_in);
	assign at  = 32'(seg.e_in - seg.v);

	pls_slope u_slope (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (slope_go),
		.ady    (ady),
		.at     (at),
		.dx     (dx),
		.done   (slope_done),
		.quo    (quo)
	);

	assign done = done_q;
	assign rsp  = out_q;

	a_chain_only_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		seg.valid |-> state_q == ST_SEARCH)
		else $error("search token left the row outside the search phase");

	a_slope_only_in_slope: assert property (@(posedge clk) disable iff (!arst_n)
		slope_done |-> state_q == ST_SLOPE)
		else $error("divider finished outside the slope phase");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_PAIRS))
		else $error("pair count beyond table size");

	a_done_after_slope: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SLOPE && slope_done |=> done && state_q == ST_IDLE)
		else $error("interpolated result not delivered");

endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench for piecewise_linear_pixel_stretch
// depends on pls_pkg and the block; predicts every result and checks it on done
`timescale 1ns / 100ps

module tb_top;
	import pls_pkg::*;

	localparam int TBL_DEPTH = MAX_PAIRS_DEF;
	localparam int WDOG_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	rsp_t        rsp;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [34:0] cfg_data;

	piecewise_linear_pixel_stretch DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [34:0]        map_reg [NUM_REGS];
	logic signed [31:0] tbl_in  [TBL_DEPTH];
	logic signed [31:0] tbl_out [TBL_DEPTH];
	int                 tbl_len;

	rsp_t pending_rsp[$];
	int   err_count;
	int   stall_cycles;
	bit   no_idle;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [2:0] fold_class(logic [2:0] c);
		return (c > CLS_HRS) ? CLS_LRS : c;
	endfunction

	function automatic rsp_t class_output(logic [34:0] r);
		rsp_t o;
		o = '0;
		o.out_class = fold_class(r[34:32]);
		o.out_value = (o.out_class == CLS_VALID) ? r[31:0] : '0;
		return o;
	endfunction

	// below/above register: a special class resolves through its class register
	function automatic rsp_t bound_output(logic [34:0] r);
		logic [2:0] c;
		rsp_t o;
		c = fold_class(r[34:32]);
		o = '0;
		if (c == CLS_VALID) o.out_value = r[31:0];
		else o = class_output(map_reg[c - 1]);
		return o;
	endfunction

	function automatic rsp_t stretch_pixel(logic [2:0] cls_in, logic signed [31:0] v);
		rsp_t o;
		int lo, hi, mid;
		longint dy, dx, t, r;
		logic [63:0] ady, at, q;
		bit neg;
		o = '0;
		if (fold_class(cls_in) != CLS_VALID) return class_output(map_reg[fold_class(cls_in) - 1]);
		if (tbl_len == 0) begin
			o.out_value = v;
			return o;
		end
		if (v < tbl_in[0]) return bound_output(map_reg[REG_BELOW]);
		if (v > tbl_in[tbl_len-1]) return bound_output(map_reg[REG_ABOVE]);
		if (v == tbl_in[0]) begin
			o.out_value = tbl_out[0];
			return o;
		end
		if (v == tbl_in[tbl_len-1]) begin
			o.out_value = tbl_out[tbl_len-1];
			return o;
		end
		lo = 0;
		hi = tbl_len - 1;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (v < tbl_in[mid]) hi = mid;
			else lo = mid;
		end
		hi = lo + 1;
		dy = longint'(tbl_out[hi]) - longint'(tbl_out[lo]);
		dx = longint'(tbl_in[hi]) - longint'(tbl_in[lo]);
		t = longint'(v) - longint'(tbl_in[hi]);
		ady = (dy < 0) ? -dy : dy;
		at = (t < 0) ? -t : t;
		neg = ((dy < 0) != (t < 0)) && ady != 0 && at != 0;
		if (dx == 0) begin
			o.out_value = tbl_out[hi];
			return o;
		end
		q = (ady * at + 64'(dx) / 2) / 64'(dx);
		r = longint'(tbl_out[hi]) + (neg ? -longint'(q) : longint'(q));
		if (r > 64'sd2147483647) begin
			o.status = STAT_SAT;
			r = 64'sd2147483647;
		end
		if (r < -64'sd2147483648) begin
			o.status = STAT_SAT;
			r = -64'sd2147483648;
		end
		o.out_value = r[31:0];
		return o;
	endfunction

	function automatic rsp_t stretch_step(req_t r);
		rsp_t o;
		o = '0;
		case (r.kind)
			KIND_CLEAR: tbl_len = 0;
			KIND_APPEND: begin
				if (tbl_len > 0 && r.value <= tbl_in[tbl_len-1]) o.status = STAT_ORDER;
				else if (tbl_len >= TBL_DEPTH) o.status = STAT_FULL;
				else begin
					tbl_in[tbl_len] = r.value;
					tbl_out[tbl_len] = r.pair_target;
					tbl_len++;
				end
			end
			KIND_MAP: o = stretch_pixel(r.in_class, r.value);
			default: ;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (done) begin
			if (pending_rsp.size() == 0) report_mismatch("unexpected result", 1, 0);
			else begin
				want = pending_rsp.pop_front();
				if (rsp.out_class !== want.out_class)
					report_mismatch("out_class", rsp.out_class, want.out_class);
				if (rsp.out_value !== want.out_value)
					report_mismatch("out_value", rsp.out_value, want.out_value);
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
			end
		end
	end

	always @(posedge clk) begin
		if (done || (start && !busy)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WDOG_LIMIT) begin
			$display("piecewise_linear_pixel_stretch verification failed");
			$finish;
		end
	end

	// one request; start stays high on return so a back-to-back one can follow
	task automatic send_req(kind_t k, logic [2:0] c, logic signed [31:0] v,
			logic signed [31:0] tgt);
		req_t r;
		rsp_t want;
		r.kind = k;
		r.in_class = c;
		r.value = v;
		r.pair_target = tgt;
		req <= r;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		want = stretch_step(r);
		pending_rsp = {pending_rsp, want};
	endtask

	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 99);
		if (no_idle || n < 50) return;
		start <= 1'b0;
		n = (n < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [34:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < NUM_REGS) map_reg[idx] = d;
		@(posedge clk);
	endtask

	task automatic pixel(logic [2:0] c, logic signed [31:0] v);
		send_req(KIND_MAP, c, v, '0);
		idle_gap();
	endtask

	task automatic append(logic signed [31:0] v, logic signed [31:0] tgt);
		send_req(KIND_APPEND, '0, v, tgt);
		idle_gap();
	endtask

	function automatic logic [34:0] rand_map(bit valid_bias);
		logic [34:0] d;
		d = {3'($urandom_range(0, 7)), $urandom};
		if (valid_bias && $urandom_range(0, 1)) d[34:32] = CLS_VALID;
		case ($urandom_range(0, 9))
			0: d[31:0] = 32'h8000_0000;
			1: d[31:0] = 32'h7fff_ffff;
			default: ;
		endcase
		return d;
	endfunction

	// ascending table of up to n pairs spread over the full input range or a tight one
	task automatic build_table(int n);
		longint cur, room;
		int i;
		send_req(KIND_CLEAR, '0, $urandom, $urandom);
		idle_gap();
		cur = $urandom_range(0, 3) == 0 ? -64'sd2147483648 :
			longint'($signed($urandom)) - 64'sd1000;
		if (cur < -64'sd2147483648) cur = -64'sd2147483648;
		for (i = 0; i < n; i++) begin
			if (cur > 64'sd2147483647) break;
			append(cur[31:0], $urandom_range(0, 5) == 0 ?
				($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000) : $urandom);
			room = (64'sd2147483647 - cur) / (n - i + 1);
			if (room < 1) room = 1;
			cur += 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) :
				longint'({$urandom, $urandom} % room));
		end
	endtask

	function automatic logic signed [31:0] rand_pixel();
		longint a, b;
		int j;
		if (tbl_len == 0 || $urandom_range(0, 9) == 0) return $urandom;
		case ($urandom_range(0, 9))
			0: return tbl_in[0] - 1;
			1: return tbl_in[tbl_len-1] + 1;
			2: return tbl_in[$urandom_range(0, tbl_len-1)];
			default: begin
				if (tbl_len < 2) return tbl_in[0];
				j = $urandom_range(0, tbl_len-2);
				a = tbl_in[j];
				b = tbl_in[j+1];
				return 32'(a + longint'({$urandom, $urandom} % (b - a + 1)));
			end
		endcase
	endfunction

	task automatic test_reset_defaults();
		int c;
		for (c = 0; c < 8; c++) pixel(3'(c), $urandom);
		pixel(CLS_VALID, 32'h8000_0000);
		pixel(CLS_VALID, 32'h7fff_ffff);
		drain();
	endtask

	task automatic test_directed();
		int i;
		write_reg(REG_BELOW, {CLS_VALID, 32'h8000_0000});
		write_reg(REG_ABOVE, {CLS_VALID, 32'h7fff_ffff});
		write_reg(3'd7, '1);
		drain();
		append(32'h8000_0000, 32'h7fff_ffff);
		append(32'h8000_0000, 32'd5);            // out of order
		append(32'h0000_0000, 32'h8000_0000);
		append(32'h7fff_ffff, 32'h7fff_ffff);
		pixel(CLS_VALID, 32'h8000_0000);
		pixel(CLS_VALID, 32'h7fff_ffff);
		pixel(CLS_VALID, 32'h8000_0001);
		pixel(CLS_VALID, 32'h7fff_fffe);
		pixel(CLS_VALID, 32'h0000_0001);
		pixel(3'd6, 32'd0);
		send_req(KIND_NONE, 3'd7, '1, '1);
		idle_gap();
		send_req(KIND_CLEAR, '0, '0, '0);
		idle_gap();
		pixel(CLS_VALID, 32'h1234_5678);
		drain();
		// full table, then an in-order and an out-of-order append on the full table
		no_idle = 1'b1;
		for (i = 0; i < TBL_DEPTH; i++) append(i * 1000 - 30000, $urandom);
		append(TBL_DEPTH * 1000, 32'd1);
		append(32'h8000_0000, 32'd1);
		pixel(CLS_VALID, 32'd500);
		pixel(CLS_VALID, 32'h7fff_ffff);
		pixel(CLS_VALID, 32'h8000_0000);
		no_idle = 1'b0;
		drain();
	endtask

	task automatic test_random_phases();
		int phase, i, r, n, sent;
		sent = 0;
		for (phase = 0; sent < 1700; phase++) begin
			drain();
			no_idle = (phase % 4 == 3);
			for (i = 0; i < NUM_REGS; i++)
				if ($urandom_range(0, 2) != 0 || phase == 0)
					write_reg(3'(i), phase == 1 ? '0 : phase == 2 ? '1 :
						rand_map(i >= REG_BELOW));
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, TBL_DEPTH + 2) :
				$urandom_range(0, 6);
			build_table(n);
			sent += n + 1;
			for (i = 0; i < 60; i++) begin
				r = $urandom_range(0, 99);
				if (r < 75) pixel(CLS_VALID, rand_pixel());
				else if (r < 85) pixel(3'($urandom_range(1, 7)), $urandom);
				else if (r < 92) append($urandom_range(0, 1) ? rand_pixel() : $urandom, $urandom);
				else if (r < 95) begin
					send_req(KIND_CLEAR, 3'($urandom), $urandom, $urandom);
					idle_gap();
				end else begin
					send_req(KIND_NONE, 3'($urandom), $urandom, $urandom);
					idle_gap();
				end
			end
			sent += 60;
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		err_count = 0;
		stall_cycles = 0;
		no_idle = 1'b0;
		tbl_len = 0;
		map_reg[REG_NULL] = RST_NULL;
		map_reg[REG_LIS] = RST_LIS;
		map_reg[REG_LRS] = RST_LRS;
		map_reg[REG_HIS] = RST_HIS;
		map_reg[REG_HRS] = RST_HRS;
		map_reg[REG_BELOW] = RST_BELOW;
		map_reg[REG_ABOVE] = RST_ABOVE;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_random_phases();
		repeat (2 * TBL_DEPTH + 40) @(posedge clk);
		if (err_count == 0 && pending_rsp.size() == 0)
			$display("piecewise_linear_pixel_stretch verification clean");
		else
			$display("piecewise_linear_pixel_stretch verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/core/pls_pkg.sv
rtl/core/pls_cell.sv
rtl/core/pls_slope.sv
rtl/core/piecewise_linear_pixel_stretch.sv
tb/tb_top.sv
